// ----- src/mwm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mwm_pkg;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_WAKE   = 2'd2,
        REQ_RAISE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        RS_NONE      = 2'd0,
        RS_PENDING   = 2'd1,
        RS_CONFIRMED = 2'd2,
        RS_FAILED    = 2'd3
    } t_raise_status;

    // configuration register indexes
    localparam logic [2:0] CFG_MOTION_ACCEL_DELTA  = 3'd0;
    localparam logic [2:0] CFG_MOTION_GYRO_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_IDLE_TIMEOUT_MS     = 3'd2;
    localparam logic [2:0] CFG_RAISE_DELTA_Y       = 3'd3;
    localparam logic [2:0] CFG_RAISE_DELTA_Z       = 3'd4;
    localparam logic [2:0] CFG_RAISE_GYRO_LIMIT    = 3'd5;
    localparam logic [2:0] CFG_RAISE_CONFIRM_COUNT = 3'd6;

    // register reset values
    localparam logic [14:0] RST_MOTION_ACCEL_DELTA  = 15'd120;
    localparam logic [14:0] RST_MOTION_GYRO_LIMIT   = 15'd120;
    localparam logic [15:0] RST_IDLE_TIMEOUT_MS     = 16'd15000;
    localparam logic [14:0] RST_RAISE_DELTA_Y       = 15'd220;
    localparam logic [14:0] RST_RAISE_DELTA_Z       = 15'd220;
    localparam logic [14:0] RST_RAISE_GYRO_LIMIT    = 15'd150;
    localparam logic [3:0]  RST_RAISE_CONFIRM_COUNT = 4'd2;

    localparam logic [15:0] MS_SAT    = 16'hFFFF;
    localparam logic [3:0]  MATCH_SAT = 4'hF;

    typedef struct packed {
        t_req               req;
        logic [2:0][14:0]   accel;   // [0] x, [1] y, [2] z
        logic [2:0][15:0]   gyro;
        logic [15:0]        window;
    } t_item;

    // exact magnitude of a 17-bit signed value whose range stays within +/-32768
    function automatic logic [15:0] mag17(input logic signed [16:0] v);
        logic signed [16:0] neg;
        neg = -v;
        return v[16] ? neg[15:0] : v[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/motion_wake_monitor.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Motion and wrist-raise monitor for an accel/gyro stream.
// Input channel s_axis: one beat per request. tuser carries the request kind
// (sample, 1 ms tick, wake, start raise check); tdata carries the sample axes
// and the raise window. Output channel m_axis: exactly one result beat per
// input beat, in order: the mode after the request, whether the sample was
// motion, and the raise-check status.
// Each beat passes through the input register, then the compare logic feeding
// the result register and the mode state.
// Throughput: one beat per cycle while m_axis does not stall; the only loop is
// the state update in the result stage.
// When m_axis stalls, the result register holds its beat and the input
// register still takes one more beat; after that s_axis_tready drops until
// the result is taken. No beat is lost or repeated.
// Reset (i_rst_n low, synchronous): both channels empty, low-rate mode, no
// raise check, all thresholds back to their defaults.
// Configuration: i_cfg_we writes register i_cfg_idx from i_cfg_data; unknown
// indexes are ignored. Write only while the block is idle.
module motion_wake_monitor
    import mwm_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write port
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [15:0]  i_cfg_data,
    // request stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: accel_x[14:0], accel_y[29:15], accel_z[44:30], gyro_x[60:45],
    //        gyro_y[76:61], gyro_z[92:77], raise_window[108:93], zero pad [111:109]
    input  wire logic [111:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: active_mode[0], motion_seen[1], raise_status[3:2], zero pad [7:4]
    output logic [7:0]        m_axis_tdata
);

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [14:0] r_motion_accel_delta;
    logic [14:0] r_motion_gyro_limit;
    logic [15:0] r_idle_timeout_ms;
    logic [14:0] r_raise_delta_y;
    logic [14:0] r_raise_delta_z;
    logic [14:0] r_raise_gyro_limit;
    logic [3:0]  r_raise_confirm_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_accel_delta  <= RST_MOTION_ACCEL_DELTA;
            r_motion_gyro_limit   <= RST_MOTION_GYRO_LIMIT;
            r_idle_timeout_ms     <= RST_IDLE_TIMEOUT_MS;
            r_raise_delta_y       <= RST_RAISE_DELTA_Y;
            r_raise_delta_z       <= RST_RAISE_DELTA_Z;
            r_raise_gyro_limit    <= RST_RAISE_GYRO_LIMIT;
            r_raise_confirm_count <= RST_RAISE_CONFIRM_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MOTION_ACCEL_DELTA:  r_motion_accel_delta  <= i_cfg_data[14:0];
                CFG_MOTION_GYRO_LIMIT:   r_motion_gyro_limit   <= i_cfg_data[14:0];
                CFG_IDLE_TIMEOUT_MS:     r_idle_timeout_ms     <= i_cfg_data;
                CFG_RAISE_DELTA_Y:       r_raise_delta_y       <= i_cfg_data[14:0];
                CFG_RAISE_DELTA_Z:       r_raise_delta_z       <= i_cfg_data[14:0];
                CFG_RAISE_GYRO_LIMIT:    r_raise_gyro_limit    <= i_cfg_data[14:0];
                CFG_RAISE_CONFIRM_COUNT: r_raise_confirm_count <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // input register and stage handshake
    // ---------------------------------------------------------------------
    logic  r_in_valid;
    t_item r_in;
    logic  r_out_valid;
    logic  adv;        // item in the input register moves to the result stage
    logic  in_accept;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.req      <= t_req'(s_axis_tuser);
            r_in.accel[0] <= s_axis_tdata[14:0];
            r_in.accel[1] <= s_axis_tdata[29:15];
            r_in.accel[2] <= s_axis_tdata[44:30];
            r_in.gyro[0]  <= s_axis_tdata[60:45];
            r_in.gyro[1]  <= s_axis_tdata[76:61];
            r_in.gyro[2]  <= s_axis_tdata[92:77];
            r_in.window   <= s_axis_tdata[108:93];
        end
    end

    // ---------------------------------------------------------------------
    // monitor state
    // ---------------------------------------------------------------------
    logic             r_mode_active;
    logic             r_baseline_valid;
    logic [2:0][14:0] r_prev_accel;
    logic [15:0]      r_idle_ms;
    logic             r_raise_busy;
    logic             r_raise_base_valid;
    logic [14:0]      r_raise_base_y;
    logic [14:0]      r_raise_base_z;
    logic [3:0]       r_raise_matches;
    logic [15:0]      r_raise_elapsed;
    logic [15:0]      r_raise_limit;

    logic             n_mode_active;
    logic             n_baseline_valid;
    logic [2:0][14:0] n_prev_accel;
    logic [15:0]      n_idle_ms;
    logic             n_raise_busy;
    logic             n_raise_base_valid;
    logic [14:0]      n_raise_base_y;
    logic [14:0]      n_raise_base_z;
    logic [3:0]       n_raise_matches;
    logic [15:0]      n_raise_elapsed;
    logic [15:0]      n_raise_limit;
    logic             n_motion;
    t_raise_status    n_status;

    // magnitudes: accel differences against the motion baseline and the
    // raise base, gyro rates; differences in 17 bits, magnitudes exact in 16
    logic [2:0][15:0] accel_chg;
    logic [2:0][15:0] gyro_mag;
    logic [15:0]      raise_chg_y;
    logic [15:0]      raise_chg_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            accel_chg[i] = mag17($signed({{2{r_in.accel[i][14]}}, r_in.accel[i]})
                               - $signed({{2{r_prev_accel[i][14]}}, r_prev_accel[i]}));
            gyro_mag[i]  = mag17($signed({r_in.gyro[i][15], r_in.gyro[i]}));
        end
        raise_chg_y = mag17($signed({{2{r_in.accel[1][14]}}, r_in.accel[1]})
                          - $signed({{2{r_raise_base_y[14]}}, r_raise_base_y}));
        raise_chg_z = mag17($signed({{2{r_in.accel[2][14]}}, r_in.accel[2]})
                          - $signed({{2{r_raise_base_z[14]}}, r_raise_base_z}));
    end

    logic motion_hit;
    logic raise_acc_hit;
    logic raise_gyro_hit;

    always_comb begin
        motion_hit = 1'b0;
        raise_gyro_hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (accel_chg[i] >= {1'b0, r_motion_accel_delta}) motion_hit = 1'b1;
            if (gyro_mag[i] >= {1'b0, r_motion_gyro_limit})   motion_hit = 1'b1;
            if (gyro_mag[i] >= {1'b0, r_raise_gyro_limit})    raise_gyro_hit = 1'b1;
        end
        raise_acc_hit = (raise_chg_y >= {1'b0, r_raise_delta_y})
                     || (raise_chg_z >= {1'b0, r_raise_delta_z});
    end

    // next state for the item in the input register; every mode change
    // drops the motion baseline
    always_comb begin
        n_mode_active      = r_mode_active;
        n_baseline_valid   = r_baseline_valid;
        n_prev_accel       = r_prev_accel;
        n_idle_ms          = r_idle_ms;
        n_raise_busy       = r_raise_busy;
        n_raise_base_valid = r_raise_base_valid;
        n_raise_base_y     = r_raise_base_y;
        n_raise_base_z     = r_raise_base_z;
        n_raise_matches    = r_raise_matches;
        n_raise_elapsed    = r_raise_elapsed;
        n_raise_limit      = r_raise_limit;
        n_motion           = 1'b0;
        n_status           = RS_NONE;

        case (r_in.req)
            REQ_SAMPLE: begin
                if (r_raise_busy) begin
                    // samples feed the raise check only
                    if (!r_raise_base_valid) begin
                        n_raise_base_y     = r_in.accel[1];
                        n_raise_base_z     = r_in.accel[2];
                        n_raise_base_valid = 1'b1;
                    end else if (raise_acc_hit && raise_gyro_hit) begin
                        if (r_raise_matches != MATCH_SAT) begin
                            n_raise_matches = r_raise_matches + 4'd1;
                        end
                        if (n_raise_matches >= r_raise_confirm_count) begin
                            n_raise_busy = 1'b0;
                            if (!n_mode_active) begin
                                n_mode_active    = 1'b1;
                                n_baseline_valid = 1'b0;
                            end
                            n_idle_ms = '0;
                            n_status  = RS_CONFIRMED;
                        end
                    end
                end else begin
                    // first sample after reset or a mode change only loads the baseline
                    if (!r_baseline_valid) begin
                        n_baseline_valid = 1'b1;
                    end else begin
                        n_motion = motion_hit;
                    end
                    n_prev_accel = r_in.accel;
                    if (n_motion) begin
                        if (!n_mode_active) begin
                            n_mode_active    = 1'b1;
                            n_baseline_valid = 1'b0;
                        end
                        n_idle_ms = '0;
                    end
                end
            end
            REQ_TICK: begin
                if (r_raise_busy) begin
                    if (r_raise_elapsed != MS_SAT) begin
                        n_raise_elapsed = r_raise_elapsed + 16'd1;
                    end
                    if (n_raise_elapsed >= r_raise_limit) begin
                        n_raise_busy = 1'b0;
                        if (n_mode_active) begin
                            n_mode_active    = 1'b0;
                            n_baseline_valid = 1'b0;
                        end
                        n_status = RS_FAILED;
                    end
                end else if (r_mode_active) begin
                    if (r_idle_ms != MS_SAT) begin
                        n_idle_ms = r_idle_ms + 16'd1;
                    end
                    if (n_idle_ms >= r_idle_timeout_ms) begin
                        n_mode_active    = 1'b0;
                        n_baseline_valid = 1'b0;
                        n_idle_ms        = '0;
                    end
                end
            end
            REQ_WAKE: begin
                if (!n_mode_active) begin
                    n_mode_active    = 1'b1;
                    n_baseline_valid = 1'b0;
                end
                n_idle_ms = '0;
            end
            default: begin
                // start (or restart) a raise check
                if (!n_mode_active) begin
                    n_mode_active    = 1'b1;
                    n_baseline_valid = 1'b0;
                end
                n_idle_ms          = '0;
                n_raise_limit      = r_in.window;
                n_raise_elapsed    = '0;
                n_raise_matches    = '0;
                n_raise_base_valid = 1'b0;
                n_raise_busy       = 1'b1;
                if (r_in.window == '0) begin
                    // empty window fails on the spot
                    n_raise_busy     = 1'b0;
                    n_mode_active    = 1'b0;
                    n_baseline_valid = 1'b0;
                    n_status         = RS_FAILED;
                end
            end
        endcase

        if (n_status == RS_NONE && n_raise_busy) begin
            n_status = RS_PENDING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_active      <= 1'b0;
            r_baseline_valid   <= 1'b0;
            r_prev_accel       <= '0;
            r_idle_ms          <= '0;
            r_raise_busy       <= 1'b0;
            r_raise_base_valid <= 1'b0;
            r_raise_base_y     <= '0;
            r_raise_base_z     <= '0;
            r_raise_matches    <= '0;
            r_raise_elapsed    <= '0;
            r_raise_limit      <= '0;
        end else if (adv) begin
            r_mode_active      <= n_mode_active;
            r_baseline_valid   <= n_baseline_valid;
            r_prev_accel       <= n_prev_accel;
            r_idle_ms          <= n_idle_ms;
            r_raise_busy       <= n_raise_busy;
            r_raise_base_valid <= n_raise_base_valid;
            r_raise_base_y     <= n_raise_base_y;
            r_raise_base_z     <= n_raise_base_z;
            r_raise_matches    <= n_raise_matches;
            r_raise_elapsed    <= n_raise_elapsed;
            r_raise_limit      <= n_raise_limit;
        end
    end

    // ---------------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------------
    logic          r_out_active;
    logic          r_out_motion;
    t_raise_status r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_active <= n_mode_active;
            r_out_motion <= n_motion;
            r_out_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_status, r_out_motion, r_out_active};

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    // a running raise check keeps the block in active mode
    a_busy_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_raise_busy |-> r_mode_active)
        else $error("raise check running in low-rate mode");

    // a confirmed raise always reports active mode
    a_confirm_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == RS_CONFIRMED) |-> r_out_active)
        else $error("confirmed raise without active mode");

    // a failed raise always reports low-rate mode
    a_fail_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == RS_FAILED) |-> !r_out_active)
        else $error("failed raise left the block active");

    // motion is reported only outside a raise check and leaves the block active
    a_motion_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_motion) |-> (r_out_active && r_out_status == RS_NONE))
        else $error("motion reported with wrong mode or raise status");

    // a result that moved up shows as valid in the result register
    a_adv_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("result stage lost a beat");

endmodule

`default_nettype wire

// ----- tb/sv/motion_wake_checker.sv -----
`timescale 1ns / 1ps

module motion_wake_checker
    import mwm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    // accel_x[14:0], accel_y[29:15], accel_z[44:30], gyro_x[60:45],
    // gyro_y[76:61], gyro_z[92:77], raise_window[108:93], zero pad [111:109]
    input  logic [111:0] i_req_data,
    // req_type[1:0]
    input  logic [1:0]   i_req_kind,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    // active_mode[0], motion_seen[1], raise_status[3:2], zero pad [7:4]
    input  logic [7:0]   i_res_data,
    output int           o_errors,
    output int           o_pending,
    output int           o_motion,
    output int           o_confirmed,
    output int           o_failed
);

    typedef struct packed {
        logic          active;
        logic          motion;
        t_raise_status raise;
    } t_outcome;

    logic [14:0]        thr_acc, thr_rate, thr_lift_y, thr_lift_z, thr_lift_rate;
    logic [15:0]        idle_limit;
    logic [3:0]         lift_need;

    logic               mode_act, base_ok;
    logic signed [14:0] prev_acc [3];
    logic [15:0]        idle_cnt;
    logic               lift_busy, lift_base_ok;
    logic signed [14:0] lift_base_y, lift_base_z;
    logic [3:0]         lift_hits;
    logic [15:0]        lift_elapsed, lift_window;

    t_outcome           outcome_q [$];
    t_outcome           fresh, want;

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic rate_hit(input logic signed [15:0] gx, gy, gz,
                                      input logic [14:0] lim);
        return iabs(int'(gx)) >= int'(lim) || iabs(int'(gy)) >= int'(lim) ||
               iabs(int'(gz)) >= int'(lim);
    endfunction

    // any mode change invalidates the motion baseline
    task automatic set_mode(input logic act);
        if (mode_act != act) begin
            mode_act = act;
            base_ok  = 1'b0;
        end
    endtask

    task automatic judge_request(input t_req kind, input logic [111:0] d,
                                 output t_outcome res);
        logic signed [14:0] ax, ay, az;
        logic signed [15:0] gx, gy, gz;
        logic [15:0]        win;
        logic               moved, tilt;
        t_raise_status      st;
        ax    = d[14:0];
        ay    = d[29:15];
        az    = d[44:30];
        gx    = d[60:45];
        gy    = d[76:61];
        gz    = d[92:77];
        win   = d[108:93];
        moved = 1'b0;
        st    = RS_NONE;
        case (kind)
            REQ_SAMPLE: begin
                if (lift_busy) begin
                    if (!lift_base_ok) begin
                        lift_base_y  = ay;
                        lift_base_z  = az;
                        lift_base_ok = 1'b1;
                    end else begin
                        tilt = iabs(int'(ay) - int'(lift_base_y)) >= int'(thr_lift_y) ||
                               iabs(int'(az) - int'(lift_base_z)) >= int'(thr_lift_z);
                        if (tilt && rate_hit(gx, gy, gz, thr_lift_rate)) begin
                            if (lift_hits < MATCH_SAT) lift_hits++;
                            if (lift_hits >= lift_need) begin
                                lift_busy = 1'b0;
                                set_mode(1'b1);
                                idle_cnt  = '0;
                                st        = RS_CONFIRMED;
                            end
                        end
                    end
                end else begin
                    if (!base_ok) begin
                        base_ok = 1'b1;
                    end else begin
                        moved = iabs(int'(ax) - int'(prev_acc[0])) >= int'(thr_acc) ||
                                iabs(int'(ay) - int'(prev_acc[1])) >= int'(thr_acc) ||
                                iabs(int'(az) - int'(prev_acc[2])) >= int'(thr_acc) ||
                                rate_hit(gx, gy, gz, thr_rate);
                    end
                    prev_acc[0] = ax;
                    prev_acc[1] = ay;
                    prev_acc[2] = az;
                    if (moved) begin
                        set_mode(1'b1);
                        idle_cnt = '0;
                    end
                end
            end
            REQ_TICK: begin
                if (lift_busy) begin
                    if (lift_elapsed < MS_SAT) lift_elapsed++;
                    if (lift_elapsed >= lift_window) begin
                        lift_busy = 1'b0;
                        set_mode(1'b0);
                        st        = RS_FAILED;
                    end
                end else if (mode_act) begin
                    if (idle_cnt < MS_SAT) idle_cnt++;
                    if (idle_cnt >= idle_limit) begin
                        set_mode(1'b0);
                        idle_cnt = '0;
                    end
                end
            end
            REQ_WAKE: begin
                set_mode(1'b1);
                idle_cnt = '0;
            end
            default: begin
                set_mode(1'b1);
                idle_cnt     = '0;
                lift_window  = win;
                lift_elapsed = '0;
                lift_hits    = '0;
                lift_base_ok = 1'b0;
                lift_busy    = 1'b1;
                if (win == '0) begin
                    lift_busy = 1'b0;
                    set_mode(1'b0);
                    st        = RS_FAILED;
                end
            end
        endcase
        if (st == RS_NONE && lift_busy) st = RS_PENDING;
        res.active = mode_act;
        res.motion = moved;
        res.raise  = st;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_acc       = RST_MOTION_ACCEL_DELTA;
            thr_rate      = RST_MOTION_GYRO_LIMIT;
            idle_limit    = RST_IDLE_TIMEOUT_MS;
            thr_lift_y    = RST_RAISE_DELTA_Y;
            thr_lift_z    = RST_RAISE_DELTA_Z;
            thr_lift_rate = RST_RAISE_GYRO_LIMIT;
            lift_need     = RST_RAISE_CONFIRM_COUNT;
            mode_act      = 1'b0;
            base_ok       = 1'b0;
            prev_acc      = '{default: '0};
            idle_cnt      = '0;
            lift_busy     = 1'b0;
            lift_base_ok  = 1'b0;
            lift_base_y   = '0;
            lift_base_z   = '0;
            lift_hits     = '0;
            lift_elapsed  = '0;
            lift_window   = '0;
            outcome_q.delete();
        end else begin
            // a result trails its request through both registers, so compare first
            if (i_res_valid && i_res_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat with no request outstanding: tdata %h", i_res_data);
                    o_errors++;
                end else begin
                    want = outcome_q.pop_front();
                    if (i_res_data[0] !== want.active) begin
                        $error("active_mode: expected %0d, got %0d",
                               want.active, i_res_data[0]);
                        o_errors++;
                    end
                    if (i_res_data[1] !== want.motion) begin
                        $error("motion_seen: expected %0d, got %0d",
                               want.motion, i_res_data[1]);
                        o_errors++;
                    end
                    if (i_res_data[3:2] !== want.raise) begin
                        $error("raise_status: expected %0d, got %0d",
                               want.raise, i_res_data[3:2]);
                        o_errors++;
                    end
                    if (want.motion) o_motion++;
                    if (want.raise == RS_CONFIRMED) o_confirmed++;
                    if (want.raise == RS_FAILED) o_failed++;
                end
            end
            if (i_req_valid && i_req_ready) begin
                judge_request(t_req'(i_req_kind), i_req_data, fresh);
                outcome_q.push_back(fresh);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MOTION_ACCEL_DELTA:  thr_acc       = i_cfg_data[14:0];
                    CFG_MOTION_GYRO_LIMIT:   thr_rate      = i_cfg_data[14:0];
                    CFG_IDLE_TIMEOUT_MS:     idle_limit    = i_cfg_data;
                    CFG_RAISE_DELTA_Y:       thr_lift_y    = i_cfg_data[14:0];
                    CFG_RAISE_DELTA_Z:       thr_lift_z    = i_cfg_data[14:0];
                    CFG_RAISE_GYRO_LIMIT:    thr_lift_rate = i_cfg_data[14:0];
                    CFG_RAISE_CONFIRM_COUNT: lift_need     = i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

// ----- tb/sv/tb_motion_wake_monitor.sv -----
`timescale 1ns / 1ps

module tb_motion_wake_monitor;
    import mwm_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 8;     // two-stage pipe plus margin
    localparam logic [2:0] CFG_UNMAPPED = 3'd7;  // no register behind this index

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [15:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // accel_x[14:0], accel_y[29:15], accel_z[44:30], gyro_x[60:45],
    // gyro_y[76:61], gyro_z[92:77], raise_window[108:93], zero pad [111:109]
    logic [111:0] s_axis_tdata;
    // req_type[1:0]
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // active_mode[0], motion_seen[1], raise_status[3:2], zero pad [7:4]
    logic [7:0]   m_axis_tdata;

    int err_count, pending, motion_cnt, confirm_cnt, fail_cnt;
    int sent, profiles, cycles, burst_left;
    int hold_left, calm_left, rx_roll;

    // tb copy of the thresholds, only used to aim the stimulus near them
    int lim_acc, lim_gyro, lim_idle, lim_ry, lim_rz, lim_rgyro;
    // current accel "posture"; quiet samples jitter around it
    int cur_acc [3];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    motion_wake_monitor DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    motion_wake_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_kind  (s_axis_tuser),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .o_errors    (err_count),
        .o_pending   (pending),
        .o_motion    (motion_cnt),
        .o_confirmed (confirm_cnt),
        .o_failed    (fail_cnt)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side backpressure: mostly short stalls, a few long ones,
    // and now and then a calm stretch with tready held high
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if (calm_left > 0) begin
                calm_left--;
            end else begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 20)      hold_left = $urandom_range(1, 3);
                else if (rx_roll < 23) hold_left = $urandom_range(10, 40);
                else if (rx_roll < 27) calm_left = $urandom_range(20, 60);
            end
        end
    end

    // two's complement wrap into the 15-bit accel range
    function automatic int wrap15(input int v);
        logic signed [14:0] t;
        t = v[14:0];
        return int'(t);
    endfunction

    // gyro reading of magnitude m, random sign; 32768 only exists as -32768
    function automatic int rate_of(input int m);
        if (m >= 32768) return -32768;
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic int rate_below(input int lim);
        return rate_of(lim > 0 ? int'($urandom_range(0, lim - 1)) : 0);
    endfunction

    function automatic int rate_over(input int lim);
        return rate_of(lim + int'($urandom_range(0, 100)));
    endfunction

    // jitter at most a third of the motion delta: two quiet samples never trip a nonzero one
    function automatic int jit(input int axis);
        int q;
        q = (lim_acc / 3 < 100) ? lim_acc / 3 : 100;
        return wrap15(cur_acc[axis] + int'($urandom_range(0, 2 * q)) - q);
    endfunction

    // one request beat; the random gap before it lands on any pipeline phase
    task automatic put_beat(input t_req kind, input logic [111:0] data);
        int roll, gap;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 4)       burst_left = $urandom_range(20, 50);
            else if (roll < 30) gap = $urandom_range(1, 3);
            else if (roll < 36) gap = $urandom_range(6, 30);
        end
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  = kind;
        s_axis_tdata  = data;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // window bits are junk on samples; the block must ignore them
    task automatic send_sample(input int ax, ay, az, gx, gy, gz);
        put_beat(REQ_SAMPLE, {3'b000, 16'($urandom), 16'(gz), 16'(gy), 16'(gx),
                              15'(az), 15'(ay), 15'(ax)});
    endtask

    // ticks, wakes and raise starts carry junk sample fields
    task automatic send_ctrl(input t_req kind, input int win);
        put_beat(kind, {3'b000, 16'(win), 93'({$urandom, $urandom, $urandom})});
    endtask

    task automatic send_quiet();
        send_sample(jit(0), jit(1), jit(2),
                    rate_below(lim_gyro), rate_below(lim_gyro), rate_below(lim_gyro));
    endtask

    task automatic send_noise();
        send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // sample during a raise check: tilt moves Y, Z or both past the limits,
    // turn puts one gyro axis at or over the raise rate limit
    task automatic send_lift(input bit tilt, input bit turn);
        int y, z, q, sel;
        int g [3];
        q   = (lim_acc / 3 < 100) ? lim_acc / 3 : 100;
        sel = $urandom_range(0, 2);
        y   = jit(1);
        z   = jit(2);
        if (tilt && sel != 1)
            y = wrap15(cur_acc[1] + ($urandom_range(0, 1) ? 1 : -1) *
                       (lim_ry + 2 * q + int'($urandom_range(0, 100))));
        if (tilt && sel != 0)
            z = wrap15(cur_acc[2] + ($urandom_range(0, 1) ? 1 : -1) *
                       (lim_rz + 2 * q + int'($urandom_range(0, 100))));
        foreach (g[i]) g[i] = rate_below(lim_rgyro);
        if (turn) g[$urandom_range(0, 2)] = rate_over(lim_rgyro);
        send_sample(jit(0), y, z, g[0], g[1], g[2]);
    endtask

    // config beats only while idle; tb copy tracks the same masking as the block
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_idx  = idx;
        i_cfg_data = data;
        i_cfg_we   = 1'b1;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            CFG_MOTION_ACCEL_DELTA: lim_acc   = int'(data[14:0]);
            CFG_MOTION_GYRO_LIMIT:  lim_gyro  = int'(data[14:0]);
            CFG_IDLE_TIMEOUT_MS:    lim_idle  = int'(data);
            CFG_RAISE_DELTA_Y:      lim_ry    = int'(data[14:0]);
            CFG_RAISE_DELTA_Z:      lim_rz    = int'(data[14:0]);
            CFG_RAISE_GYRO_LIMIT:   lim_rgyro = int'(data[14:0]);
            default: ;
        endcase
    endtask

    task automatic set_profile(input logic [15:0] acc, rate, idle, dy, dz, lrate, need);
        write_reg(CFG_MOTION_ACCEL_DELTA, acc);
        write_reg(CFG_MOTION_GYRO_LIMIT, rate);
        write_reg(CFG_IDLE_TIMEOUT_MS, idle);
        write_reg(CFG_RAISE_DELTA_Y, dy);
        write_reg(CFG_RAISE_DELTA_Z, dz);
        write_reg(CFG_RAISE_GYRO_LIMIT, lrate);
        write_reg(CFG_RAISE_CONFIRM_COUNT, need);
        profiles++;
    endtask

    // drop tvalid, wait for every owed result, then let the pipe empty
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // random traffic: raise-check episodes (start, base, mostly matching samples,
    // ticks, wakes) and motion episodes (quiet samples, bumps, gyro bursts, tick
    // runs that can reach the idle timeout, wakes), with some noise sprinkled into both
    task automatic run_phase(input int target);
        int roll, kind_roll, n, win, axis;
        int g [3];
        while (sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                kind_roll = $urandom_range(0, 99);
                if (kind_roll < 6)       win = 0;
                else if (kind_roll < 10) win = 16'hFFFF;
                else                     win = $urandom_range(1, 40);
                send_ctrl(REQ_RAISE, win);
                send_quiet();
                n = $urandom_range(2, 10);
                repeat (n) begin
                    kind_roll = $urandom_range(0, 99);
                    if (kind_roll < 55)      send_lift(1'b1, 1'b1);
                    else if (kind_roll < 65) send_lift(1'b1, 1'b0);
                    else if (kind_roll < 72) send_lift(1'b0, 1'b1);
                    else if (kind_roll < 92) send_ctrl(REQ_TICK, $urandom);
                    else if (kind_roll < 96) send_ctrl(REQ_WAKE, $urandom);
                    else                     send_noise();
                end
            end else begin
                n = $urandom_range(3, 12);
                repeat (n) begin
                    kind_roll = $urandom_range(0, 99);
                    if (kind_roll < 50) begin
                        send_quiet();
                    end else if (kind_roll < 75) begin
                        axis = $urandom_range(0, 2);
                        cur_acc[axis] = wrap15(cur_acc[axis] +
                                               ($urandom_range(0, 1) ? 1 : -1) *
                                               (lim_acc + int'($urandom_range(0, 50))));
                        send_sample(cur_acc[0], cur_acc[1], cur_acc[2], rate_below(lim_gyro),
                                    rate_below(lim_gyro), rate_below(lim_gyro));
                    end else if (kind_roll < 90) begin
                        foreach (g[i]) g[i] = rate_below(lim_gyro);
                        g[$urandom_range(0, 2)] = rate_over(lim_gyro);
                        send_sample(jit(0), jit(1), jit(2), g[0], g[1], g[2]);
                    end else begin
                        send_noise();
                    end
                end
                kind_roll = $urandom_range(0, 99);
                if (kind_roll < 60) begin
                    n = $urandom_range(1, (lim_idle + 2 < 40) ? lim_idle + 2 : 40);
                    repeat (n) send_ctrl(REQ_TICK, $urandom);
                end else if (kind_roll < 75) begin
                    send_ctrl(REQ_WAKE, $urandom);
                end
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_MOTION_ACCEL_DELTA;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_SAMPLE;
        lim_acc       = int'(RST_MOTION_ACCEL_DELTA);
        lim_gyro      = int'(RST_MOTION_GYRO_LIMIT);
        lim_idle      = int'(RST_IDLE_TIMEOUT_MS);
        lim_ry        = int'(RST_RAISE_DELTA_Y);
        lim_rz        = int'(RST_RAISE_DELTA_Z);
        lim_rgyro     = int'(RST_RAISE_GYRO_LIMIT);
        cur_acc       = '{0, 0, 0};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, reset thresholds
        send_sample(16383, 16383, 16383, 0, 0, 0);           // first sample only loads
        send_sample(-16384, -16384, -16384, 0, 0, 0);        // full-scale swing -> active
        send_sample(-16384, -16384, -16384, -32768, 0, 0);   // baseline reload after mode change
        send_sample(-16384, -16384, -16384, -32768, 0, 0);   // |-32768| counts as motion
        send_sample(-16384, -16384, -16384, 0, 32767, -20000);
        send_sample(-16384, -16384, -16384, 0, 0, 0);        // quiet
        send_ctrl(REQ_TICK, 0);
        send_ctrl(REQ_WAKE, 0);
        send_ctrl(REQ_RAISE, 0);                             // zero window fails at once
        send_ctrl(REQ_RAISE, 3);
        send_sample(0, 0, 0, 0, 0, 0);                       // raise base
        send_sample(0, 300, 0, 0, 200, 0);                   // first match
        send_ctrl(REQ_TICK, 0);
        send_sample(0, 0, -300, 0, 0, -200);                 // second match confirms
        send_ctrl(REQ_RAISE, 2);
        send_ctrl(REQ_TICK, 0);
        send_ctrl(REQ_TICK, 0);                              // window expires
        send_ctrl(REQ_RAISE, 16'hFFFF);
        send_sample(0, 100, 100, 0, 0, 0);
        send_ctrl(REQ_WAKE, 0);                              // check keeps running
        send_ctrl(REQ_RAISE, 5);                             // restart
        send_sample(0, 100, 100, 0, 0, 0);
        send_sample(0, 600, 100, 0, 0, 0);                   // tilt without turn
        send_sample(0, 100, 100, 32767, 0, 0);               // turn without tilt
        send_sample(0, 100, -200, -32768, 0, 0);             // match, still pending
        settle();

        // everything at zero: every sample past a baseline load is motion, one match confirms,
        // first tick times out; also an unmapped index that must be ignored
        set_profile(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        write_reg(CFG_UNMAPPED, 16'h5A5A);
        run_phase(sent + 80);
        settle();

        // all ones: 15-bit registers keep their low bits, confirm needs 15 matches
        set_profile(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(sent + 80);
        settle();

        set_profile(16'd100, 16'd100, 16'd5, 16'd200, 16'd200, 16'd150, 16'd2);
        run_phase(sent + 80);
        settle();

        set_profile(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                    16'($urandom_range(1, 30)), 16'($urandom_range(0, 600)),
                    16'($urandom_range(0, 600)), 16'($urandom_range(0, 400)),
                    16'($urandom_range(1, 4)));
        run_phase(sent + 80);
        settle();

        set_profile(16'd120, 16'd120, 16'd10, 16'd220, 16'd220, 16'd150, 16'd1);
        run_phase(sent + 80);
        settle();

        $display("Sent %0d request beats across %0d threshold settings plus reset values.",
                 sent, profiles);
        $display("Outcomes seen: %0d motion samples, %0d raises confirmed, %0d checks failed.",
                 motion_cnt, confirm_cnt, fail_cnt);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
